// File: sv/nec_ir_remote_decoder_defines.svh
// Assertion macros for the NEC IR decoder RTL.
// Included by nec_ir_remote_decoder, which carries the concurrent checks; depends on nothing.
`ifndef NEC_IR_REMOTE_DECODER_DEFINES_SVH
`define NEC_IR_REMOTE_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NIR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nir_pkg.sv
// Package for the NEC IR decoder: opcodes, pulse classes and timing windows.
// Used by nir_pulse_classify and nec_ir_remote_decoder; depends on nothing.
`timescale 1ns / 1ps

package nir_pkg;

   localparam int UsWidth   = 14;
   localparam int SilWidth  = 4;

   // silence ticks after the first before a leader times out
   localparam logic [SilWidth-1:0] TimeoutTicks = 4'd14;

   // pulse windows in microseconds, both bounds exclusive
   localparam logic [UsWidth-1:0] Bit0Lo = 14'd300;
   localparam logic [UsWidth-1:0] Bit0Hi = 14'd800;
   localparam logic [UsWidth-1:0] Bit1Lo = 14'd1400;
   localparam logic [UsWidth-1:0] Bit1Hi = 14'd1800;
   localparam logic [UsWidth-1:0] RepLo  = 14'd2200;
   localparam logic [UsWidth-1:0] RepHi  = 14'd2600;
   localparam logic [UsWidth-1:0] LeadLo = 14'd4200;
   localparam logic [UsWidth-1:0] LeadHi = 14'd4700;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_EDGE = 2'd1,
      OP_SCAN = 2'd2
   } opcode_type;

   // one-hot pulse class from the window compare
   typedef enum logic [4:0] {
      PULSE_NONE   = 5'b00001,
      PULSE_BIT0   = 5'b00010,
      PULSE_BIT1   = 5'b00100,
      PULSE_REPEAT = 5'b01000,
      PULSE_LEADER = 5'b10000
   } pulse_type;

endpackage

// File: sv/nir_pulse_classify.sv
// Classifies a measured high time into an NEC pulse class.
// Depends on nir_pkg for the window bounds and the class encoding.
`timescale 1ns / 1ps

module nir_pulse_classify
   import nir_pkg::*;
(
   input  logic [UsWidth-1:0] width_us,
   output pulse_type          pulse_class
);

   logic in_bit0;
   logic in_bit1;
   logic in_rep;
   logic in_lead;

   // exclusive window compares, windows do not overlap
   assign in_bit0 = (width_us > Bit0Lo) && (width_us < Bit0Hi);
   assign in_bit1 = (width_us > Bit1Lo) && (width_us < Bit1Hi);
   assign in_rep  = (width_us > RepLo)  && (width_us < RepHi);
   assign in_lead = (width_us > LeadLo) && (width_us < LeadHi);

   // encode the hit
   always_comb begin
      priority if (in_bit0) begin
         pulse_class = PULSE_BIT0;
      end else if (in_bit1) begin
         pulse_class = PULSE_BIT1;
      end else if (in_rep) begin
         pulse_class = PULSE_REPEAT;
      end else if (in_lead) begin
         pulse_class = PULSE_LEADER;
      end else begin
         pulse_class = PULSE_NONE;
      end
   end

endmodule

// File: sv/nec_ir_remote_decoder.sv
// rsp_tvalid rises once the req item has passed the input register and then the result register.
// Throughput: one transaction per cycle unless rsp_tready stalls; one decode pass per item.
// rsp_tready low holds the result register and the input register behind it.
// Reset (synchronous, active high) clears the decode flags, counters, the shift word
// and the address register, and empties both pipeline registers.
`timescale 1ns / 1ps
`include "nec_ir_remote_decoder_defines.svh"

module nec_ir_remote_decoder
   import nir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // event input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] pin_level, [14:1] captured_us, [15] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // decoder status output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] key_code, [15:8] repeat_count,
                                    // [16] frame_ready, [17] leader_active, [23:18] zero
   // address register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_op_ff;
   logic               s1_pin_ff;
   logic [UsWidth-1:0] s1_us_ff;

   // decode state
   logic                leader_ff, leader_in;
   logic                ready_ff, ready_in;
   logic                rising_ff, rising_in;
   logic [SilWidth-1:0] sil_ff, sil_in;
   logic [31:0]         shift_ff, shift_in;
   logic [7:0]          rep_ff, rep_in;
   logic [7:0]          addr_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] key_ff, key_in;
   logic [7:0] rsp_rep_ff;
   logic       rsp_ready_flag_ff;
   logic       rsp_leader_ff;

   logic       advance;
   logic       take;
   pulse_type  pulse_class;
   logic [7:0] addr_byte, naddr_byte, cmd_byte, ncmd_byte;
   logic       frame_ok;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign take       = s1_valid_ff && advance;
   assign csr_ready  = 1'b1;

   nir_pulse_classify u_classify (
      .width_us    (s1_us_ff),
      .pulse_class (pulse_class)
   );

   // frame check on the shifted word
   assign addr_byte  = shift_ff[31:24];
   assign naddr_byte = shift_ff[23:16];
   assign cmd_byte   = shift_ff[15:8];
   assign ncmd_byte  = shift_ff[7:0];
   assign frame_ok   = (addr_byte == ~naddr_byte) && (addr_byte == addr_ff)
                       && (cmd_byte == ~ncmd_byte);

   // next decode state for the item in the input register
   always_comb begin
      leader_in = leader_ff;
      ready_in  = ready_ff;
      rising_in = rising_ff;
      sil_in    = sil_ff;
      shift_in  = shift_ff;
      rep_in    = rep_ff;
      key_in    = 8'd0;
      unique case (opcode_type'(s1_op_ff))
         OP_TICK: begin
            if (leader_ff) begin
               rising_in = 1'b0;
               if (sil_ff == '0) begin
                  ready_in = 1'b1;
               end
               if (sil_ff < TimeoutTicks) begin
                  sil_in = sil_ff + 1'b1;
               end else begin
                  leader_in = 1'b0;
                  sil_in    = '0;
               end
            end
         end
         OP_EDGE: begin
            if (s1_pin_ff) begin
               rising_in = 1'b1;
            end else begin
               rising_in = 1'b0;
               if (rising_ff) begin
                  if (leader_ff) begin
                     if (pulse_class == PULSE_BIT0) begin
                        shift_in = {shift_ff[30:0], 1'b0};
                     end else if (pulse_class == PULSE_BIT1) begin
                        shift_in = {shift_ff[30:0], 1'b1};
                     end else if (pulse_class == PULSE_REPEAT) begin
                        rep_in = rep_ff + 8'd1;
                        sil_in = '0;
                     end
                  end else if (pulse_class == PULSE_LEADER) begin
                     leader_in = 1'b1;
                     rep_in    = 8'd0;
                  end
               end
            end
         end
         OP_SCAN: begin
            if (ready_ff) begin
               key_in = frame_ok ? cmd_byte : 8'd0;
               if (!frame_ok || (cmd_byte == 8'd0) || !leader_ff) begin
                  ready_in = 1'b0;
                  rep_in   = 8'd0;
               end
            end
         end
         default: begin
            // unused opcode: status only
         end
      endcase
   end

   assign s1_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         leader_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         rising_ff    <= 1'b0;
         sil_ff       <= '0;
         shift_ff     <= '0;
         rep_ff       <= '0;
         addr_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            leader_ff <= leader_in;
            ready_ff  <= ready_in;
            rising_ff <= rising_in;
            sil_ff    <= sil_in;
            shift_ff  <= shift_in;
            rep_ff    <= rep_in;
         end
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_data;
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff  <= req_tuser;
         s1_pin_ff <= req_tdata[0];
         s1_us_ff  <= req_tdata[14:1];
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (take) begin
         key_ff            <= key_in;
         rsp_rep_ff        <= rep_in;
         rsp_ready_flag_ff <= ready_in;
         rsp_leader_ff     <= leader_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_leader_ff, rsp_ready_flag_ff, rsp_rep_ff, key_ff};

   // silence count stays within the timeout bound
   `NIR_ASSERT_NOW(a_sil_bound, clock, reset, 1'b1, sil_ff <= TimeoutTicks, "silence count over bound")
   // silence only counts while a leader is held
   `NIR_ASSERT_NOW(a_sil_leader, clock, reset, sil_ff != '0, leader_ff, "silence count without leader")
   // a taken item always lands in the result register
   `NIR_ASSERT_NEXT(a_take_rsp, clock, reset, take, rsp_valid_ff, "taken item lost")
   // the reported leader flag matches the state after the item
   `NIR_ASSERT_NEXT(a_rsp_leader, clock, reset, take, rsp_leader_ff == leader_ff, "leader mismatch")

endmodule
